>>> rtl/lsce_pkg.sv
package lsce_pkg;

  localparam int MAX_DEGREE = 15;
  localparam int WORD_BITS  = 32;

  localparam int WORD_W     = 32;
  localparam int FRAC_BITS  = 24;
  localparam int SAT_BITS   = (WORD_BITS > WORD_W) ? WORD_W : WORD_BITS;
  localparam int DEGREE_W   = 4;
  localparam int INDEX_W    = 4;
  localparam int CFG_IDX_W  = 2;

  localparam int COEF_DEPTH = MAX_DEGREE + 1;
  localparam int DEG_W      = $clog2(COEF_DEPTH);
  localparam int PROD_W     = 2 * WORD_W;
  localparam int ACC_W      = PROD_W - FRAC_BITS + DEG_W + 1;
  localparam int NUM_W      = WORD_W + DEG_W + 2;
  localparam int DIV_RADIX_BITS = 8;
  localparam int DIV_STEPS  = (NUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int DIV_W      = DIV_STEPS * DIV_RADIX_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef logic signed [WORD_W-1:0]  word_t;
  typedef logic signed [PROD_W-1:0]  wide_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic [DEG_W-1:0]          deg_t;
  typedef logic [DEGREE_W-1:0]       degree_t;
  typedef logic [INDEX_W-1:0]        coef_idx_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEGREE      = 2'd0,
    REG_TIME_SCALE  = 2'd1,
    REG_TIME_OFFSET = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_EVAL = 1'b1
  } func_t;

  localparam degree_t DEGREE_RST      = degree_t'(10);
  localparam word_t   TIME_SCALE_RST  = word_t'(33554432);
  localparam word_t   TIME_OFFSET_RST = word_t'(8388608);

  localparam word_t ONE_Q  = word_t'(64'sd1 <<< FRAC_BITS);
  localparam wide_t SAT_HI = (wide_t'(1) <<< (SAT_BITS - 1)) - wide_t'(1);
  localparam wide_t SAT_LO = -SAT_HI - wide_t'(1);

endpackage

>>> rtl/lsce_if.sv
interface lsce_cfg_if;
  logic               valid;
  logic               ready;
  lsce_pkg::cfg_idx_t index;
  lsce_pkg::word_t    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

interface lsce_req_if;
  logic                valid;
  logic                ready;
  lsce_pkg::func_t     func;
  lsce_pkg::coef_idx_t coef_index;
  lsce_pkg::word_t     coef_value;
  lsce_pkg::word_t     sample_time;

  modport source(output valid, func, coef_index, coef_value, sample_time, input ready);
  modport sink(input valid, func, coef_index, coef_value, sample_time, output ready);
endinterface

interface lsce_rsp_if;
  logic            valid;
  logic            ready;
  lsce_pkg::word_t radius;
  lsce_pkg::word_t radius_rate;
  logic            saturated;

  modport source(output valid, radius, radius_rate, saturated, input ready);
  modport sink(input valid, radius, radius_rate, saturated, output ready);
endinterface

>>> rtl/legendre_series_curve_eval.sv
// Legendre series curve evaluator, Q8.24 fixed point.
// cfg: register writes (degree, time_scale, time_offset); always ready, write
//   only while no evaluation is in flight.
// req: func = load writes coef_value to coefficient coef_index;
//   func = eval starts a series evaluation at sample_time.
// rsp: one transaction per eval with radius, radius_rate and saturated.
// An eval of n = min(degree, MAX_DEGREE) has its result valid and req ready
// again in the same cycle, and req is not ready while an eval is in flight.
// Per degree: two coefficient products and, below degree n, one product on
// the shared 32x32 multiplier for xi*P and a radix-256 divider for the
// division by i. Coefficients sit in a 16-entry synchronous RAM.
// The result sits in an output register: while it waits, req stays ready, so
// loads and the next eval proceed; an eval that finishes while the previous
// result is still held waits until rsp is taken.
// Reset (rst, synchronous) returns to idle, drops rsp valid and restores the
// register defaults (degree 10, scale 2.0, offset 0.5); coefficients are
// undefined until loaded.
module legendre_series_curve_eval (
  input  logic       clk,
  input  logic       rst,
  lsce_cfg_if.sink   cfg,
  lsce_req_if.sink   req,
  lsce_rsp_if.source rsp
);

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_XI_MUL = 13'b0000000000010,
    ST_TS_MUL = 13'b0000000000100,
    ST_INIT   = 13'b0000000001000,
    ST_CMUL_P = 13'b0000000010000,
    ST_CMUL_D = 13'b0000000100000,
    ST_CACC   = 13'b0000001000000,
    ST_MMUL   = 13'b0000010000000,
    ST_NUM    = 13'b0000100000000,
    ST_DIV    = 13'b0001000000000,
    ST_FIN_R  = 13'b0010000000000,
    ST_FIN_RR = 13'b0100000000000,
    ST_DONE   = 13'b1000000000000
  } state_t;

  function automatic lsce_pkg::word_t sat_word(input lsce_pkg::wide_t v);
    if (v > lsce_pkg::SAT_HI) begin
      return lsce_pkg::SAT_HI[lsce_pkg::WORD_W-1:0];
    end else if (v < lsce_pkg::SAT_LO) begin
      return lsce_pkg::SAT_LO[lsce_pkg::WORD_W-1:0];
    end
    return v[lsce_pkg::WORD_W-1:0];
  endfunction

  function automatic logic clipped(input lsce_pkg::wide_t v);
    return (v > lsce_pkg::SAT_HI) || (v < lsce_pkg::SAT_LO);
  endfunction

  state_t state;
  state_t state_next;

  lsce_pkg::degree_t cfg_degree;
  lsce_pkg::word_t   time_scale;
  lsce_pkg::word_t   time_offset;

  lsce_pkg::word_t coef_mem [lsce_pkg::COEF_DEPTH];
  lsce_pkg::word_t coef_rd;

  lsce_pkg::deg_t deg;
  lsce_pkg::deg_t n_lim;
  lsce_pkg::word_t t_reg;
  lsce_pkg::word_t diff;
  lsce_pkg::word_t xi;
  lsce_pkg::word_t ts;
  lsce_pkg::word_t p1;
  lsce_pkg::word_t p2;
  lsce_pkg::word_t d1;
  lsce_pkg::word_t d2;
  lsce_pkg::word_t dn;
  lsce_pkg::word_t s_w;
  lsce_pkg::word_t d_w;
  lsce_pkg::word_t r_val;
  logic            r_clip;
  lsce_pkg::acc_t  s_acc;
  lsce_pkg::acc_t  d_acc;

  lsce_pkg::word_t mul_a;
  lsce_pkg::word_t mul_b;
  logic            mul_en;
  lsce_pkg::wide_t prod;
  lsce_pkg::wide_t prod_q;

  logic [lsce_pkg::DEG_W:0]          k_odd;
  logic signed [lsce_pkg::DEG_W+1:0] k_odd_s;
  logic signed [lsce_pkg::DEG_W+1:0] k_m1_s;
  lsce_pkg::word_t                   m_c;
  logic signed [lsce_pkg::NUM_W-1:0] num_c;
  logic [lsce_pkg::NUM_W-1:0]        mag_c;
  lsce_pkg::word_t                   dn_c;

  logic [lsce_pkg::DIV_W-1:0]     div_quo;
  logic [lsce_pkg::DEG_W-1:0]     div_rem;
  logic                           div_neg;
  logic [lsce_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [lsce_pkg::DIV_W-1:0]     quo_step;
  logic [lsce_pkg::DEG_W-1:0]     rem_step;
  logic [lsce_pkg::DEG_W:0]       rem_ext;
  lsce_pkg::wide_t                q_signed;

  lsce_pkg::wide_t rr_sum;
  logic            out_valid;
  logic            out_free;
  lsce_pkg::word_t out_radius;
  lsce_pkg::word_t out_rate;
  logic            out_sat;

  logic eval_acc;
  logic load_acc;

  assign cfg.ready       = 1'b1;
  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.radius      = out_radius;
  assign rsp.radius_rate = out_rate;
  assign rsp.saturated   = out_sat;

  assign eval_acc = req.valid && req.ready && (req.func == lsce_pkg::FUNC_EVAL);
  assign load_acc = req.valid && req.ready && (req.func == lsce_pkg::FUNC_LOAD);
  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    if (32'(cfg_degree) > lsce_pkg::MAX_DEGREE) begin
      n_lim = lsce_pkg::DEG_W'(lsce_pkg::MAX_DEGREE);
    end else begin
      n_lim = lsce_pkg::DEG_W'(cfg_degree);
    end
  end

  // recurrence terms for k = deg
  assign k_odd   = {deg, 1'b0} - (lsce_pkg::DEG_W + 1)'(1);
  assign k_odd_s = $signed({1'b0, k_odd});
  assign k_m1_s  = $signed({2'b00, deg - lsce_pkg::DEG_W'(1)});
  assign prod_q  = prod >>> lsce_pkg::FRAC_BITS;
  assign m_c     = sat_word(prod_q);
  assign num_c   = lsce_pkg::NUM_W'(m_c) * lsce_pkg::NUM_W'(k_odd_s)
                 - lsce_pkg::NUM_W'(p2) * lsce_pkg::NUM_W'(k_m1_s);
  assign mag_c   = num_c[lsce_pkg::NUM_W-1] ? lsce_pkg::NUM_W'(-num_c)
                                            : lsce_pkg::NUM_W'(num_c);
  assign dn_c    = sat_word(lsce_pkg::PROD_W'(d2)
                 + lsce_pkg::PROD_W'(p1) * lsce_pkg::PROD_W'(k_odd_s));
  assign rr_sum  = lsce_pkg::PROD_W'(s_w) + prod_q;

  // restoring divide by k, one radix-256 digit per cycle
  always_comb begin
    quo_step = div_quo;
    rem_step = div_rem;
    rem_ext  = '0;
    for (int j = 0; j < lsce_pkg::DIV_RADIX_BITS; j++) begin
      rem_ext  = {rem_step, quo_step[lsce_pkg::DIV_W-1]};
      quo_step = quo_step << 1;
      if (rem_ext >= {1'b0, deg}) begin
        rem_ext     = rem_ext - {1'b0, deg};
        quo_step[0] = 1'b1;
      end
      rem_step = rem_ext[lsce_pkg::DEG_W-1:0];
    end
  end

  assign q_signed = div_neg ? -$signed(lsce_pkg::PROD_W'(quo_step))
                            : $signed(lsce_pkg::PROD_W'(quo_step));

  always_comb begin
    mul_en = 1'b1;
    mul_a  = t_reg;
    mul_b  = time_scale;
    unique case (state)
      ST_XI_MUL: begin
        mul_a = time_scale;
        mul_b = diff;
      end
      ST_TS_MUL: begin
        mul_a = t_reg;
        mul_b = time_scale;
      end
      ST_CMUL_P: begin
        mul_a = coef_rd;
        mul_b = p1;
      end
      ST_CMUL_D: begin
        mul_a = coef_rd;
        mul_b = d1;
      end
      ST_MMUL: begin
        mul_a = xi;
        mul_b = p1;
      end
      ST_FIN_R: begin
        mul_a = t_reg;
        mul_b = sat_word(lsce_pkg::PROD_W'(s_acc));
      end
      ST_FIN_RR: begin
        mul_a = ts;
        mul_b = d_w;
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (eval_acc) state_next = ST_XI_MUL;
      ST_XI_MUL: state_next = ST_TS_MUL;
      ST_TS_MUL: state_next = ST_INIT;
      ST_INIT:   state_next = ST_CMUL_P;
      ST_CMUL_P: state_next = ST_CMUL_D;
      ST_CMUL_D: state_next = ST_CACC;
      ST_CACC:   state_next = (deg == n_lim) ? ST_FIN_R : ST_MMUL;
      ST_MMUL:   state_next = ST_NUM;
      ST_NUM:    state_next = ST_DIV;
      ST_DIV:    if (div_cnt == '0) state_next = ST_CMUL_P;
      ST_FIN_R:  state_next = ST_FIN_RR;
      ST_FIN_RR: state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      cfg_degree  <= lsce_pkg::DEGREE_RST;
      time_scale  <= lsce_pkg::TIME_SCALE_RST;
      time_offset <= lsce_pkg::TIME_OFFSET_RST;
      deg         <= '0;
      div_cnt     <= '0;
      p1          <= '0;
      p2          <= '0;
      d1          <= '0;
      d2          <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        unique case (lsce_pkg::cfg_reg_t'(cfg.index))
          lsce_pkg::REG_DEGREE:      cfg_degree  <= cfg.data[lsce_pkg::DEGREE_W-1:0];
          lsce_pkg::REG_TIME_SCALE:  time_scale  <= cfg.data;
          lsce_pkg::REG_TIME_OFFSET: time_offset <= cfg.data;
          default: ;
        endcase
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (eval_acc) begin
        deg <= '0;
      end else if (state == ST_CACC && deg != n_lim) begin
        deg <= deg + lsce_pkg::DEG_W'(1);
      end
      if (state == ST_NUM) begin
        div_cnt <= lsce_pkg::DIV_CNT_W'(lsce_pkg::DIV_STEPS - 1);
      end else if (state == ST_DIV) begin
        div_cnt <= div_cnt - lsce_pkg::DIV_CNT_W'(1);
      end
      if (state == ST_INIT) begin
        p1 <= lsce_pkg::ONE_Q;
        p2 <= '0;
        d1 <= '0;
        d2 <= '0;
      end else if (state == ST_DIV && div_cnt == '0) begin
        p2 <= p1;
        p1 <= sat_word(q_signed);
        d2 <= d1;
        d1 <= dn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_acc && 32'(req.coef_index) <= lsce_pkg::MAX_DEGREE) begin
      coef_mem[lsce_pkg::DEG_W'(req.coef_index)] <= req.coef_value;
    end
    coef_rd <= coef_mem[deg];
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= lsce_pkg::PROD_W'(mul_a) * lsce_pkg::PROD_W'(mul_b);
    end
    if (eval_acc) begin
      t_reg <= req.sample_time;
      diff  <= sat_word(lsce_pkg::PROD_W'(req.sample_time)
                      - lsce_pkg::PROD_W'(time_offset));
    end
    if (state == ST_TS_MUL) begin
      xi <= sat_word(prod_q);
    end
    if (state == ST_INIT) begin
      ts    <= sat_word(prod_q);
      s_acc <= '0;
      d_acc <= '0;
    end
    if (state == ST_CMUL_D) begin
      s_acc <= s_acc + lsce_pkg::ACC_W'(prod_q);
    end
    if (state == ST_CACC) begin
      d_acc <= d_acc + lsce_pkg::ACC_W'(prod_q);
    end
    if (state == ST_NUM) begin
      div_quo <= lsce_pkg::DIV_W'(mag_c);
      div_rem <= '0;
      div_neg <= num_c[lsce_pkg::NUM_W-1];
      dn      <= dn_c;
    end
    if (state == ST_DIV) begin
      div_quo <= quo_step;
      div_rem <= rem_step;
    end
    if (state == ST_FIN_R) begin
      s_w <= sat_word(lsce_pkg::PROD_W'(s_acc));
      d_w <= sat_word(lsce_pkg::PROD_W'(d_acc));
    end
    if (state == ST_FIN_RR) begin
      r_val  <= sat_word(prod_q);
      r_clip <= clipped(prod_q);
    end
    if (state == ST_DONE && out_free) begin
      out_radius <= r_val;
      out_rate   <= sat_word(rr_sum);
      out_sat    <= r_clip | clipped(rr_sum);
    end
  end

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && !rsp.ready) |=> (state == ST_DONE && out_valid))
    else $error("finished result overwrote a held transaction");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready && state != ST_DONE) |=> !rsp.valid)
    else $error("output valid stayed after transaction with no new result");

  a_eval_start: assert property (@(posedge clk) disable iff (rst)
    eval_acc |=> (state == ST_XI_MUL && deg == '0))
    else $error("evaluation did not start at degree zero");

  a_deg_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMUL_P) |-> (deg <= n_lim))
    else $error("degree counter ran past the series length");

  a_div_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_cnt != '0) |=> (state == ST_DIV))
    else $error("divider left before its last digit");

endmodule
